// ===== rtl/multi_tone_sine_synthesizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-tone sine synthesizer
// Short forms for clocked properties with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH
`define MULTI_TONE_SINE_SYNTHESIZER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MTSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtss: assertion failed");

// Next-cycle implication, ignored while reset is high.
`define MTSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtss: assertion failed");

// Next-cycle implication that also holds across reset.
`define MTSS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mtss: assertion failed");

`endif

// ===== rtl/mtss_pkg.sv =====
// ----------------------------------------------------------------------------
// mtss_pkg
// Shared types, field layout, register indexes and the sine table builder.
// ----------------------------------------------------------------------------
package mtss_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TONE_W   = 16;
  localparam int SUM_W    = 18;
  localparam int SETUP_W  = 64;
  localparam int CNT_W    = 3;

  // Setup register layout
  localparam int AMP_LSB = 48;
  localparam int OFF_LSB = 32;
  localparam int OFF_W   = 16;
  localparam int INC_W   = 32;

  // Register indexes
  localparam int REG_TONE_COUNT = 0;
  localparam int REG_TONE_BASE  = 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef logic signed [TONE_W-1:0] tone_val_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Sine generation constants, Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // One quarter-wave entry in Q1.15: sine at the middle of bin k, Taylor
  // series to the x^17 term with every product and quotient truncated.
  function automatic logic [15:0] sine_entry(input int unsigned k,
                                             input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] scaled;
    x    = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (bits + 1);
    term = x;
    acc  = x;
    for (int j = 0; j < 8; j++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[j];
      if (j % 2 == 0) begin
        acc = (acc >= term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    scaled = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    return scaled[15:0];
  endfunction

endpackage

// ===== rtl/mtss_tone.sv =====
// ----------------------------------------------------------------------------
// mtss_tone
// One tone lane: phase multiply, quadrant fold, table read, amplitude scale.
// ----------------------------------------------------------------------------
module mtss_tone
  import mtss_pkg::*;
#(
  parameter int PHASE_BITS = 32,
  parameter int TABLE_BITS = 10
) (
  input  logic                clk,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample_index,
  input  logic [SETUP_W-1:0]  setup,
  input  logic                active,
  output tone_val_t           value
);

  localparam int TABLE_LEN = 2 ** TABLE_BITS;
  localparam int MULT_W    = SAMPLE_W + PHASE_BITS;

  logic [TONE_W-1:0] rom [TABLE_LEN];

  for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
    localparam logic [TONE_W-1:0] ENTRY = sine_entry(g, TABLE_BITS);
    assign rom[g] = ENTRY;
  end

  logic [PHASE_BITS-1:0]   inc;
  logic [MULT_W-1:0]       mult;
  logic [PHASE_BITS-1:0]   phase_mul;
  logic [PHASE_BITS-1:0]   phase;
  logic [TABLE_BITS+1:0]   top_bits;
  logic [TABLE_BITS-1:0]   addr;
  logic                    neg;
  logic [TONE_W-1:0]       rom_q;
  tone_val_t               sine;
  tone_val_t               amp;
  logic signed [2*TONE_W-1:0] prod;

  assign inc  = setup[PHASE_BITS-1:0];
  assign amp  = setup[SETUP_W-1:AMP_LSB];
  assign mult = {{PHASE_BITS{1'b0}}, sample_index} * {{SAMPLE_W{1'b0}}, inc};

  assign phase    = phase_mul
                  + (PHASE_BITS'(setup[OFF_LSB +: OFF_W]) << (PHASE_BITS - OFF_W));
  assign top_bits = phase[PHASE_BITS-1 -: TABLE_BITS+2];
  assign rom_q    = rom[addr];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: index times increment, keep the wrapping phase bits
      phase_mul <= mult[PHASE_BITS-1:0];
      // stage 2: add offset, mirror odd quadrants, flag the negative half
      addr <= top_bits[TABLE_BITS] ? ~top_bits[TABLE_BITS-1:0]
                                   : top_bits[TABLE_BITS-1:0];
      neg  <= top_bits[TABLE_BITS+1];
      // stage 3: table read with sign
      sine <= neg ? -$signed(rom_q) : $signed(rom_q);
      // stage 4: amplitude scale
      prod <= amp * sine;
      // stage 5: floor shift by 15, zero an idle tone
      value <= active ? prod[TONE_W+14:15] : '0;
    end
  end

endmodule

// ===== rtl/mtss_out.sv =====
// ----------------------------------------------------------------------------
// mtss_out
// Sum and saturate the tone samples, pack them, hold them in a two-item buffer.
// ----------------------------------------------------------------------------
module mtss_out
  import mtss_pkg::*;
#(
  parameter int NUM_TONES = 4,
  parameter int DATA_W    = 88
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tone_val_t         tones [NUM_TONES],
  output logic              full,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata
);

  localparam int ACC_W = TONE_W + 4;

  logic signed [ACC_W-1:0] acc;
  sum_t                    sum;
  logic [DATA_W-1:0]       packed_data;
  logic [DATA_W-1:0]       store [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              count;
  logic                    pop;

  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      acc = acc + ACC_W'(tones[i]);
    end
    if (acc > ACC_W'(SUM_MAX)) begin
      sum = SUM_MAX;
    end else if (acc < ACC_W'(SUM_MIN)) begin
      sum = SUM_MIN;
    end else begin
      sum = acc[SUM_W-1:0];
    end
  end

  always_comb begin
    packed_data = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      packed_data[i*TONE_W +: TONE_W] = tones[i];
    end
    packed_data[NUM_TONES*TONE_W +: SUM_W] = sum;
  end

  assign m_tvalid = (count != 2'd0);
  assign full     = (count == 2'd2);
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= packed_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/multi_tone_sine_synthesizer.sv =====
// ----------------------------------------------------------------------------
// multi_tone_sine_synthesizer
// Direct digital synthesis of up to NUM_TONES sine tones and their sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one item per sample index. Each item yields one
//   result on the output stream (m_axis_*): every tone sample and their sum.
//   Configuration: write tone_count at index 0 and tone i setup at index
//   1 + i through cfg_we / cfg_index / cfg_data, only while no item is in
//   flight. Writes to indexes past the last tone are dropped.
//   Throughput: one item per clock, sustained, while the output is taken.
//   Pipeline: input register, five lane stages, then the output buffer; the
//   two phase and amplitude multipliers and the table read set the stage split.
//   Reset (rst, synchronous): tone_count = 1, all setups zero, pipeline and
//   output buffer empty.
//   Stall: the two-item output buffer decouples the sides; when it is full
//   the whole pipeline holds and s_axis_tready drops, so nothing is lost or
//   repeated.
// ----------------------------------------------------------------------------
module multi_tone_sine_synthesizer
  import mtss_pkg::*;
#(
  parameter int NUM_TONES       = 4,
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS      = 32,
  localparam int CFG_IDX_W      = $clog2(NUM_TONES + 1),
  localparam int OUT_W          = ((NUM_TONES * TONE_W + SUM_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SETUP_W-1:0]   cfg_data,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,  // [23:0] sample_index
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata   // tone_0_value .. tone_N-1_value
                                              // (16 bits each), sum_value (18),
                                              // zero pad to bytes
);

  // input register plus five lane stages
  localparam int LAT = 6;

  logic [CNT_W-1:0]    tone_count;
  logic [SETUP_W-1:0]  setup [NUM_TONES];
  logic [NUM_TONES-1:0] active;

  logic                adv;
  logic                full;
  logic [LAT-1:0]      vld;
  logic [SAMPLE_W-1:0] sample_index;
  tone_val_t           tones [NUM_TONES];

  // Configuration registers; indexes past the last tone fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_count <= CNT_W'(1);
      for (int i = 0; i < NUM_TONES; i++) begin
        setup[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_W'(REG_TONE_COUNT)) begin
        tone_count <= cfg_data[CNT_W-1:0];
      end
      for (int i = 0; i < NUM_TONES; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_TONE_BASE + i)) begin
          setup[i] <= cfg_data;
        end
      end
    end
  end

  // A tone is live when its number is below tone_count.
  always_comb begin
    for (int i = 0; i < NUM_TONES; i++) begin
      active[i] = (tone_count > CNT_W'(i));
    end
  end

  // Whole pipeline advances together while the output buffer has room.
  assign adv           = ~full;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // Hold the sample index for the lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      sample_index <= s_axis_tdata;
    end
  end

  for (genvar t = 0; t < NUM_TONES; t++) begin : g_tone
    mtss_tone #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (SINE_TABLE_BITS)
    ) u_tone (
      .clk          (clk),
      .en           (adv),
      .sample_index (sample_index),
      .setup        (setup[t]),
      .active       (active[t]),
      .value        (tones[t])
    );
  end

  mtss_out #(
    .NUM_TONES (NUM_TONES),
    .DATA_W    (OUT_W)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (adv & vld[LAT-1]),
    .tones    (tones),
    .full     (full),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/mtss_checker.sv =====
// ----------------------------------------------------------------------------
// mtss_checker
// Port-level checks of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_tone_sine_synthesizer_macros.svh"

module mtss_checker
  import mtss_pkg::*;
#(
  parameter int NUM_TONES = 4,
  localparam int OUT_W     = ((NUM_TONES * TONE_W + SUM_W + 7) / 8) * 8
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OUT_W-1:0]     m_axis_tdata
);

  localparam int ACC_W = TONE_W + 4;

  logic signed [ACC_W-1:0] acc;
  sum_t                    expect_sum;
  logic                    sum_ok;

  // Rebuild the saturated sum from the tone fields of the output item.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      acc = acc + ACC_W'($signed(m_axis_tdata[i*TONE_W +: TONE_W]));
    end
    if (acc > ACC_W'(SUM_MAX)) begin
      expect_sum = SUM_MAX;
    end else if (acc < ACC_W'(SUM_MIN)) begin
      expect_sum = SUM_MIN;
    end else begin
      expect_sum = acc[SUM_W-1:0];
    end
    sum_ok = (m_axis_tdata[NUM_TONES*TONE_W +: SUM_W] == expect_sum);
  end

  `MTSS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_axis_tvalid)
  `MTSS_ASSERT_NEXT_ALWAYS(a_reset_ready, clk, rst, s_axis_tready)
  `MTSS_ASSERT_IMPL(a_sum_matches, clk, rst, m_axis_tvalid, sum_ok)
  `MTSS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind multi_tone_sine_synthesizer mtss_checker #(.NUM_TONES(NUM_TONES)) u_checker (.*);

// ===== tb/tb_multi_tone_sine_synthesizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multi-tone sine synthesizer
// Streams sample indexes through the block under a range of tone settings
// and compares every tone sample and the tone sum against a local model
// built from its own quarter-wave sine table. Both stream sides idle at
// random, the output side holds off once long enough to stall the input,
// and settings change only while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_multi_tone_sine_synthesizer;
  import mtss_pkg::*;

  localparam int NUM_TONES    = 4;
  localparam int TABLE_BITS   = 10;
  localparam int TABLE_LEN    = 1 << TABLE_BITS;
  localparam int CFG_IDX_W    = $clog2(NUM_TONES + 1);
  localparam int OUT_W        = ((NUM_TONES * TONE_W + SUM_W + 7) / 8) * 8;
  localparam int PAD_W        = OUT_W - NUM_TONES * TONE_W - SUM_W;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE       = 8;       // a bit over the pipeline depth
  localparam int HOLD_CYCLES  = 300;     // long output hold-off
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q2.30
  localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;

  // Result layout, lowest bits first: tone 0 .. tone 3, sum, zero pad
  typedef struct packed {
    logic [PAD_W-1:0]              pad;
    sum_t                          total;
    tone_val_t [NUM_TONES-1:0]     tone;
  } synth_out_t;

  // Clock, reset and block ports; every input is known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SETUP_W-1:0]   cfg_data  = '0;
  logic                 s_valid   = 1'b0;
  logic                 s_ready;
  logic [SAMPLE_W-1:0]  s_data    = '0;
  logic                 m_valid;
  logic                 m_ready   = 1'b0;
  logic [OUT_W-1:0]     m_data;

  always #2 clk = ~clk;

  multi_tone_sine_synthesizer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  // Local copy of the settings, kept in step with every register write
  logic [CNT_W-1:0]   count_shadow = 3'd1;
  logic [SETUP_W-1:0] setup_shadow [NUM_TONES] = '{default: '0};

  int          sine_quarter [TABLE_LEN];
  synth_out_t  pending_samples [$];

  // Stream side controls
  bit src_idle_on  = 1'b0;
  bit sink_idle_on = 1'b0;
  int hold_reqs    = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int cycle_count     = 0;

  // --------------------------------------------------------------------------
  // Sine table: odd Taylor series to x^17 in Q2.30, every step truncated,
  // sampled at the middle of each quarter-wave bin and rounded to Q1.15.
  // --------------------------------------------------------------------------
  function automatic longint unsigned taylor_sine_q30(longint unsigned x);
    longint unsigned term;
    longint unsigned acc;
    term = x;
    acc  = x;
    for (int n = 1; n < 17; n += 2) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((n + 1) * (n + 2));
      if (((n + 1) / 2) % 2 == 1) begin
        acc = (acc >= term) ? acc - term : 0;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > UNIT_Q30) begin
      acc = UNIT_Q30;
    end
    return acc;
  endfunction

  initial begin
    for (int k = 0; k < TABLE_LEN; k++) begin
      sine_quarter[k] = int'((taylor_sine_q30(((64'(k) * 2 + 1) * QUARTER_TURN_Q30)
                                             >> (TABLE_BITS + 1)) * 64'd32767
                             + (64'd1 << 29)) >> 30);
    end
  end

  // One tone: phase = n * increment + offset (wrapping turn fraction),
  // quadrant from the top two phase bits, then amplitude * sine, floor >> 15.
  function automatic tone_val_t tone_sample(logic [SETUP_W-1:0] setup,
                                            logic [SAMPLE_W-1:0] n);
    logic [31:0]  phase;
    logic [11:0]  top;
    logic [9:0]   bin;
    int           sine;
    longint       prod;
    phase = 32'(64'(n) * 64'(setup[INC_W-1:0])) + {setup[OFF_LSB +: OFF_W], 16'h0000};
    top   = phase[31:20];
    bin   = top[9:0];
    if (top[10]) begin
      bin = ~bin;                  // mirror for the falling quadrants
    end
    sine = sine_quarter[bin];
    if (top[11]) begin
      sine = -sine;                // negate for the second half turn
    end
    prod = longint'($signed(setup[AMP_LSB +: 16])) * longint'(sine);
    return tone_val_t'(prod >>> 15);
  endfunction

  // Full result for one sample index under the current settings
  function automatic synth_out_t synthesize_sample(logic [SAMPLE_W-1:0] n);
    synth_out_t r;
    tone_val_t  v;
    int         acc;
    r   = '0;
    acc = 0;
    for (int i = 0; i < NUM_TONES; i++) begin
      if (i < int'(count_shadow)) begin
        v         = tone_sample(setup_shadow[i], n);
        r.tone[i] = v;
        acc       = acc + int'(v);
      end
    end
    // clamp to the sum width (out of reach with four tones)
    if (acc > int'(SUM_MAX)) acc = int'(SUM_MAX);
    if (acc < int'(SUM_MIN)) acc = int'(SUM_MIN);
    r.total = sum_t'(acc);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stream driver: optionally idle, then offer one item and hold it until
  // it is taken. Record the expected result at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [SAMPLE_W-1:0] idx);
    if (src_idle_on) begin
      while ($urandom_range(99) < 30) begin
        s_valid <= 1'b0;
        @(posedge clk);
      end
    end
    s_valid <= 1'b1;
    s_data  <= idx;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    pending_samples.push_back(synthesize_sample(idx));
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding result, then let the
  // pipeline settle before anything touches the registers.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: one cycle with the enable high; mirror it locally.
  task automatic write_reg(input int idx, input logic [SETUP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TONE_COUNT) begin
      count_shadow = value[CNT_W-1:0];
    end else if (idx >= REG_TONE_BASE && idx < REG_TONE_BASE + NUM_TONES) begin
      setup_shadow[idx - REG_TONE_BASE] = value;
    end
    @(posedge clk);
  endtask

  function automatic logic [SETUP_W-1:0] pack_setup(logic [15:0] amp,
                                                    logic [15:0] offset,
                                                    logic [31:0] incr);
    return {amp, offset, incr};
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random tready, a long hold-off on request, and a
  // checker that compares each taken result with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      m_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (sink_idle_on) begin
      m_ready <= ($urandom_range(99) >= 30);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    synth_out_t got;
    synth_out_t want;
    if (!rst && m_valid && m_ready) begin
      got = m_data;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        results_checked++;
        for (int i = 0; i < NUM_TONES; i++) begin
          if (got.tone[i] !== want.tone[i]) begin
            $display("%0t: tone %0d expected %0d actual %0d", $time, i,
                     want.tone[i], got.tone[i]);
            errors++;
          end
        end
        if (got.total !== want.total) begin
          $display("%0t: sum expected %0d actual %0d", $time, want.total, got.total);
          errors++;
        end
        if (got.pad !== want.pad) begin
          $display("%0t: pad expected %h actual %h", $time, want.pad, got.pad);
          errors++;
        end
      end
    end
  end

  // Hard stop in case the stream locks up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               pending_samples.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Straight out of reset: one tone, zero setup, so every sample is zero.
  task automatic test_reset_defaults();
    send_sample('0);
    send_sample('1);
    wait_drained();
    settings_used++;
  endtask

  // Tone count of zero, tone counts past the last tone, and writes to
  // indexes past the last tone, which must be dropped.
  task automatic test_register_map();
    for (int i = 0; i < NUM_TONES; i++) begin
      write_reg(REG_TONE_BASE + i, pack_setup(16'h4000 + 16'(i), 16'h1000 * 16'(i),
                                              32'h0123_4567 * (i + 1)));
    end
    write_reg(REG_TONE_COUNT, 64'd0);
    send_sample(24'd5);
    send_sample(24'hABCDEF);
    wait_drained();
    // only the low three bits count; junk above them
    write_reg(REG_TONE_COUNT, {61'h1555_5555_5555_5555, 3'd7});
    send_sample(24'd7);
    send_sample(24'h123456);
    wait_drained();
    for (int idx = REG_TONE_BASE + NUM_TONES; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(idx, {$urandom, $urandom});
    end
    send_sample(24'd99);
    wait_drained();
    settings_used += 3;
  endtask

  // Amplitude, offset and increment extremes, quadrant boundaries, the
  // index range ends, and the largest tone sums of either sign.
  task automatic test_extreme_tones();
    write_reg(REG_TONE_COUNT, 64'd4);
    write_reg(REG_TONE_BASE + 0, pack_setup(16'h7FFF, 16'h4000, 32'h0000_0000));
    write_reg(REG_TONE_BASE + 1, pack_setup(16'h8000, 16'hC000, 32'h0000_0000));
    write_reg(REG_TONE_BASE + 2, pack_setup(16'h8000, 16'h8000, 32'hFFFF_FFFF));
    write_reg(REG_TONE_BASE + 3, pack_setup(16'h7FFF, 16'hFFFF, 32'h0010_0000));
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'd2);
    send_sample(24'd3);
    send_sample(24'd1023);
    send_sample(24'd1024);
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'hFFFFFF);
    wait_drained();
    for (int i = 0; i < NUM_TONES; i++) begin
      write_reg(REG_TONE_BASE + i, pack_setup(16'h8000, 16'h4000, 32'h0));
    end
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    wait_drained();
    for (int i = 0; i < NUM_TONES; i++) begin
      write_reg(REG_TONE_BASE + i, pack_setup(16'h7FFF, 16'h4000, 32'h0));
    end
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    wait_drained();
    settings_used += 3;
  endtask

  // Random setup for one tone, with a bias toward the interesting corners
  function automatic logic [SETUP_W-1:0] random_setup();
    logic [SETUP_W-1:0] s;
    s = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;                                                     // fully random
      1: s[63:48] = ($urandom_range(1) == 1) ? 16'h7FFF : 16'h8000;
      2: s[31:0]  = 32'($urandom_range(65535));                // slow tone
      3: s[47:32] = 16'h0000;
      default: ;
    endcase
    return s;
  endfunction

  // Random index: running sequences as a signal source would use,
  // plus wide random values, small values and the range ends.
  function automatic logic [SAMPLE_W-1:0] next_index(logic [SAMPLE_W-1:0] prev);
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return prev + 1'b1;
    if (pick < 70) return SAMPLE_W'($urandom);
    if (pick < 90) return SAMPLE_W'($urandom_range(255));
    return ($urandom_range(1) == 1) ? '1 : '0;
  endfunction

  // Several phases, each a fresh set of registers followed by a stream of
  // random indexes. One phase runs with no idling on either side.
  task automatic test_random_tones(input int phases, input int per_phase);
    logic [SAMPLE_W-1:0] idx;
    int                  count;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0:       count = 4;
        1:       count = 1;
        2:       count = 7;
        3:       count = 0;
        default: count = $urandom_range(7);
      endcase
      write_reg(REG_TONE_COUNT, {$urandom, 29'($urandom), 3'(count)});
      for (int i = 0; i < NUM_TONES; i++) begin
        write_reg(REG_TONE_BASE + i, random_setup());
      end
      src_idle_on  = (p != 4);
      sink_idle_on = (p != 4);
      idx = SAMPLE_W'($urandom);
      for (int n = 0; n < per_phase; n++) begin
        idx = next_index(idx);
        send_sample(idx);
      end
      wait_drained();
      settings_used++;
    end
  endtask

  // Hold the output off for a long stretch while the input keeps
  // offering items, so the pipeline fills and tready drops.
  task automatic test_output_holdoff();
    logic [SAMPLE_W-1:0] idx;
    write_reg(REG_TONE_COUNT, 64'd4);
    for (int i = 0; i < NUM_TONES; i++) begin
      write_reg(REG_TONE_BASE + i, random_setup());
    end
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    hold_reqs++;
    idx = SAMPLE_W'($urandom);
    for (int n = 0; n < 60; n++) begin
      idx = idx + 1'b1;
      send_sample(idx);
    end
    wait_drained();
    settings_used++;
  endtask

  // Sender pauses mid-stream until every result is back, then resumes
  // under the same settings.
  task automatic test_pause_until_drained();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (int n = 0; n < 30; n++) send_sample(SAMPLE_W'($urandom));
    s_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    for (int n = 0; n < 30; n++) send_sample(SAMPLE_W'($urandom));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, then each test in turn
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_map();
    test_extreme_tones();
    test_random_tones(12, 140);
    test_output_holdoff();
    test_pause_until_drained();
    wait_drained();
    $display("Streamed %0d sample indexes and checked %0d results over %0d tone settings,",
             items_sent, results_checked, settings_used);
    $display("including zero and overfull tone counts, dropped writes and a long output stall.");
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mtss_pkg.sv
rtl/mtss_tone.sv
rtl/mtss_out.sv
rtl/multi_tone_sine_synthesizer.sv
rtl/mtss_checker.sv
tb/tb_multi_tone_sine_synthesizer.sv
